// ===== rtl/chained_hash_table_with_free_list_macros.svh =====
// Assertion macros used by the hash table RTL.
`ifndef CHAINED_HASH_TABLE_WITH_FREE_LIST_MACROS_SVH
`define CHAINED_HASH_TABLE_WITH_FREE_LIST_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CHTFL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("chtfl: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define CHTFL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("chtfl: next-cycle check failed");

`endif

// ===== rtl/chtfl_pkg.sv =====
// Shared widths, request codes and status codes of the hash table.
`timescale 1ns / 1ps

package chtfl_pkg;

	localparam int BKEY_W     = 8;
	localparam int KEY_W      = 32;
	localparam int DATA_W     = 32;
	localparam int STATUS_W   = 3;
	localparam int SLOT_OUT_W = 5;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_HOME     = 3'd0,
		ST_OVERFLOW = 3'd1,
		ST_DUP      = 3'd2,
		ST_FULL     = 3'd3,
		ST_FOUND    = 3'd4,
		ST_MISSING  = 3'd5
	} status_t;

endpackage

// ===== rtl/chtfl_req_if.sv =====
// Request channel: valid/ready handshake carrying one table request.
`timescale 1ns / 1ps

interface chtfl_req_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [chtfl_pkg::BKEY_W-1:0]  bucket_key;
	logic [chtfl_pkg::KEY_W-1:0]   member_key;
	logic [chtfl_pkg::DATA_W-1:0]  record_data;

	modport source (
		output valid, req_type, bucket_key, member_key, record_data,
		input  ready
	);

	modport sink (
		input  valid, req_type, bucket_key, member_key, record_data,
		output ready
	);
endinterface

// ===== rtl/chtfl_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one table result.
`timescale 1ns / 1ps

interface chtfl_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [chtfl_pkg::STATUS_W-1:0]    status;
	logic [chtfl_pkg::SLOT_OUT_W-1:0]  slot_index;
	logic [chtfl_pkg::DATA_W-1:0]      found_data;

	modport source (
		output valid, status, slot_index, found_data,
		input  ready
	);

	modport sink (
		input  valid, status, slot_index, found_data,
		output ready
	);
endinterface

// ===== rtl/chtfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module chtfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/chtfl_home.sv =====
// Home slot index: (bucket_key - 1) mod HOMES via reciprocal multiply, two stages.
`timescale 1ns / 1ps

module chtfl_home #(
	parameter int HOMES = 4,
	parameter int SW    = 5
) (
	input  logic                         clk,
	input  logic [chtfl_pkg::BKEY_W-1:0] bkey,
	output logic [SW-1:0]                home
);

	localparam int VW = chtfl_pkg::BKEY_W + 1;
	localparam int SH = 18;
	localparam int PW = VW + SH + 1;
	localparam longint unsigned RECIP = (64'd1 << SH) / HOMES;

	logic [VW-1:0]   v;
	logic [PW-1:0]   prod;
	logic [VW-1:0]   v_s1;
	logic [VW-1:0]   q_s1;
	logic [2*VW-1:0] qh;
	logic [VW-1:0]   r0;
	logic [VW-1:0]   r1;
	logic [SW-1:0]   home_s2;

	// Adding HOMES - 1 keeps the wrap of a zero key inside the unsigned range.
	assign v    = VW'(bkey) + VW'(HOMES - 1);
	assign prod = PW'(v) * PW'(RECIP);

	always_ff @(posedge clk) begin
		v_s1 <= v;
		q_s1 <= VW'(prod >> SH);
	end

	// Quotient estimate is low by at most one, so one correction suffices.
	assign qh = (2*VW)'(q_s1) * (2*VW)'(HOMES);
	assign r0 = v_s1 - qh[VW-1:0];
	assign r1 = (r0 >= VW'(HOMES)) ? (r0 - VW'(HOMES)) : r0;

	always_ff @(posedge clk) begin
		home_s2 <= SW'(r1);
	end

	assign home = home_s2;

endmodule

// ===== rtl/chained_hash_table_with_free_list.sv =====
// A request is taken in idle, waits for its home index in the hash state, reads the home slot and
// then checks the chain entries one at a time through the single RAM read port; an overflow store
// adds a tail link write-back. A request with key zero goes straight to the response state. One
// request is in flight at a time, and the response state waits while an earlier result is unaccepted.
// Reset clears the home valid bits and sets the free-list head at once; overflow slots come
// alive as the head passes them, so there is no clearing pass and no wait after reset.
`timescale 1ns / 1ps
`include "chained_hash_table_with_free_list_macros.svh"

module chained_hash_table_with_free_list #(
	parameter int SLOTS   = 32,
	parameter int BUCKETS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	chtfl_req_if.sink   req,
	chtfl_rsp_if.source rsp
);

	localparam int SW    = $clog2(SLOTS);
	localparam int LW    = SW + 1;
	localparam int HOMES = (BUCKETS < SLOTS) ? BUCKETS : SLOTS;
	localparam int HIW   = (HOMES > 1) ? $clog2(HOMES) : 1;
	localparam logic [LW-1:0] LINK_NULL = LW'(SLOTS);
	localparam logic [LW-1:0] HOMES_L   = LW'(HOMES);

	typedef struct packed {
		logic [chtfl_pkg::KEY_W-1:0]  key;
		logic [chtfl_pkg::DATA_W-1:0] payload;
		logic [LW-1:0]                link;
	} entry_t;

	localparam int EW = $bits(entry_t);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_HASH  = 6'b000010,
		S_READ  = 6'b000100,
		S_CHECK = 6'b001000,
		S_LINK  = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t                           state_q;
	chtfl_pkg::req_t                  req_q;
	logic [chtfl_pkg::KEY_W-1:0]      key_q;
	logic [chtfl_pkg::DATA_W-1:0]     data_q;
	logic [SW-1:0]                    cur_q;
	logic                             rd_vld_s1;
	logic [LW-1:0]                    fh_q;
	logic [HOMES-1:0]                 home_vld_q;
	chtfl_pkg::status_t               res_status_q;
	logic [SW-1:0]                    res_slot_q;
	logic [chtfl_pkg::DATA_W-1:0]     res_data_q;
	logic                             out_vld_q;
	chtfl_pkg::status_t               out_status_q;
	logic [chtfl_pkg::SLOT_OUT_W-1:0] out_slot_q;
	logic [chtfl_pkg::DATA_W-1:0]     out_data_q;

	logic [SW-1:0]                    home_idx;
	logic                             ram_we;
	logic [SW-1:0]                    ram_waddr;
	entry_t                           ram_wdata;
	logic                             ram_re;
	logic [SW-1:0]                    ram_raddr;
	logic [EW-1:0]                    ram_rdata;

	entry_t                           rd_entry;
	logic [chtfl_pkg::KEY_W-1:0]      key_rd;
	logic [LW-1:0]                    link_rd;
	logic                             hit;
	logic                             link_end;
	logic                             fh_null;
	logic                             accept;
	logic                             out_load;

	logic                             chk_walk;
	logic                             chk_done;
	logic                             chk_store_home;
	logic                             chk_append;
	chtfl_pkg::status_t               chk_status;
	logic [SW-1:0]                    chk_slot;
	logic [chtfl_pkg::DATA_W-1:0]     chk_data;

	// Overflow slots are live once read through a link; home slots need their valid bit.
	function automatic logic slot_live(input logic [SW-1:0] a, input logic [HOMES-1:0] vld);
		return (LW'(a) >= HOMES_L) || vld[a[HIW-1:0]];
	endfunction

	chtfl_home #(
		.HOMES (HOMES),
		.SW    (SW)
	) u_home (
		.clk  (clk),
		.bkey (req.bucket_key),
		.home (home_idx)
	);

	chtfl_ram #(
		.WIDTH (EW),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign accept   = req.valid && req.ready;
	assign out_load = (state_q == S_RESP) && (!out_vld_q || rsp.ready);

	// An entry never written reads as empty key and null link.
	assign rd_entry = entry_t'(ram_rdata);
	assign key_rd   = rd_vld_s1 ? rd_entry.key : '0;
	assign link_rd  = rd_vld_s1 ? rd_entry.link : LINK_NULL;
	assign hit      = (key_rd == key_q);
	assign link_end = (link_rd >= LINK_NULL);
	assign fh_null  = (fh_q >= LINK_NULL);

	always_comb begin
		chk_walk       = 1'b0;
		chk_done       = 1'b0;
		chk_store_home = 1'b0;
		chk_append     = 1'b0;
		chk_status     = chtfl_pkg::ST_MISSING;
		chk_slot       = '0;
		chk_data       = '0;
		if (req_q == chtfl_pkg::REQ_LOOKUP) begin
			if (hit) begin
				chk_done   = 1'b1;
				chk_status = chtfl_pkg::ST_FOUND;
				chk_slot   = cur_q;
				chk_data   = rd_entry.payload;
			end else if (link_end) begin
				chk_done   = 1'b1;
			end else begin
				chk_walk   = 1'b1;
			end
		end else begin
			if (key_rd == '0) begin
				chk_done       = 1'b1;
				chk_store_home = 1'b1;
				chk_status     = chtfl_pkg::ST_HOME;
				chk_slot       = cur_q;
			end else if (hit) begin
				chk_done   = 1'b1;
				chk_status = chtfl_pkg::ST_DUP;
				chk_slot   = cur_q;
			end else if (link_end) begin
				if (fh_null) begin
					chk_done   = 1'b1;
					chk_status = chtfl_pkg::ST_FULL;
				end else begin
					chk_append = 1'b1;
				end
			end else begin
				chk_walk = 1'b1;
			end
		end
	end

	// Memory port steering: home read, chain reads straight from the returned link,
	// new-slot write while checking, tail link write-back afterwards.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = home_idx;
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = '{key: key_q, payload: data_q, link: LINK_NULL};
		case (state_q)
			S_READ: begin
				ram_re = 1'b1;
			end
			S_CHECK: begin
				if (chk_walk) begin
					ram_re    = 1'b1;
					ram_raddr = link_rd[SW-1:0];
				end
				if (chk_store_home) begin
					ram_we = 1'b1;
				end
				if (chk_append) begin
					ram_we    = 1'b1;
					ram_waddr = fh_q[SW-1:0];
				end
			end
			S_LINK: begin
				// Read data still holds the chain tail, so key and payload go back unchanged.
				ram_we    = 1'b1;
				ram_wdata = '{key: rd_entry.key, payload: rd_entry.payload, link: fh_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= chtfl_pkg::REQ_INSERT;
			key_q        <= '0;
			data_q       <= '0;
			cur_q        <= '0;
			rd_vld_s1    <= 1'b0;
			fh_q         <= (HOMES < SLOTS) ? HOMES_L : LINK_NULL;
			home_vld_q   <= '0;
			res_status_q <= chtfl_pkg::ST_MISSING;
			res_slot_q   <= '0;
			res_data_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q  <= chtfl_pkg::req_t'(req.req_type);
						key_q  <= req.member_key;
						data_q <= req.record_data;
						if (req.member_key == '0) begin
							res_status_q <= (req.req_type == chtfl_pkg::REQ_LOOKUP) ?
								chtfl_pkg::ST_MISSING : chtfl_pkg::ST_DUP;
							res_slot_q   <= '0;
							res_data_q   <= '0;
							state_q      <= S_RESP;
						end else begin
							state_q      <= S_HASH;
						end
					end
				end
				S_HASH: begin
					state_q <= S_READ;
				end
				S_READ: begin
					cur_q     <= home_idx;
					rd_vld_s1 <= slot_live(home_idx, home_vld_q);
					state_q   <= S_CHECK;
				end
				S_CHECK: begin
					if (chk_walk) begin
						cur_q     <= link_rd[SW-1:0];
						rd_vld_s1 <= slot_live(link_rd[SW-1:0], home_vld_q);
					end else if (chk_append) begin
						res_status_q <= chtfl_pkg::ST_OVERFLOW;
						res_slot_q   <= fh_q[SW-1:0];
						res_data_q   <= '0;
						state_q      <= S_LINK;
					end else if (chk_done) begin
						res_status_q <= chk_status;
						res_slot_q   <= chk_slot;
						res_data_q   <= chk_data;
						if (chk_store_home) begin
							home_vld_q[cur_q[HIW-1:0]] <= 1'b1;
						end
						state_q      <= S_RESP;
					end
				end
				S_LINK: begin
					// Overflow slots are chained in index order, so the next free one is fh + 1.
					fh_q    <= fh_q + LW'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: a finished result waits here while the next request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q    <= 1'b0;
			out_status_q <= chtfl_pkg::ST_MISSING;
			out_slot_q   <= '0;
			out_data_q   <= '0;
		end else begin
			if (out_load) begin
				out_vld_q    <= 1'b1;
				out_status_q <= res_status_q;
				out_slot_q   <= chtfl_pkg::SLOT_OUT_W'(res_slot_q);
				out_data_q   <= res_data_q;
			end else if (rsp.ready) begin
				out_vld_q    <= 1'b0;
			end
		end
	end

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = out_vld_q;
	assign rsp.status     = out_status_q;
	assign rsp.slot_index = out_slot_q;
	assign rsp.found_data = out_data_q;

	`CHTFL_ASSERT_IMP(a_fh_range, clk, arst_n, 1'b1, (fh_q >= HOMES_L) && (fh_q <= LINK_NULL))
	`CHTFL_ASSERT_IMP(a_no_rw_clash, clk, arst_n, ram_we, !ram_re)
	`CHTFL_ASSERT_NXT(a_fh_step, clk, arst_n, state_q == S_LINK, fh_q == $past(fh_q) + LW'(1))
	`CHTFL_ASSERT_IMP(a_chain_overflow, clk, arst_n, (state_q == S_CHECK) && ram_re, LW'(ram_raddr) >= HOMES_L)

endmodule
